@@ rtl/bfa_pkg.sv @@
// Shared types, constants and sizes for the bitmap frame allocator.
package bfa_pkg;

    // Map geometry and frame size.
    localparam int NUM_FRAMES  = 1024;
    localparam int FRAME_SHIFT = 12;

    // The used map is kept as words; there are always at least two of them.
    localparam int WORD_W    = (NUM_FRAMES >= 64) ? 32 : NUM_FRAMES / 2;
    localparam int NUM_WORDS = NUM_FRAMES / WORD_W;
    localparam int WORD_SH   = $clog2(WORD_W);
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int FIDX_W    = $clog2(NUM_FRAMES);

    // Field widths fixed by the interface.
    localparam int BASE_W  = 20;
    localparam int COUNT_W = 11;
    localparam int START_W = 11;
    localparam int ADDR_W  = 32;

    // Request kinds.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_FRAME     = 2'd1,
        ST_MISALIGNED   = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic                 action;
        logic [START_W-1:0]   start_index;
        logic [ADDR_W-1:0]    free_address;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ADDR_W-1:0]    frame_address;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;      // capture the request
        logic    first_rd;  // read the first map word
        logic    next_rd;   // step to and read the next map word
        logic    wr;        // write back the modified map word
        logic    fin;       // latch the result
        t_status code;      // status to latch with fin
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    is_free;   // request frees a frame
        logic    chk_ok;    // request passed its checks
        t_status chk_code;  // failure status when the checks fail
        logic    found;     // a free frame sits in the current word
        logic    last_word; // the current word is the last one in range
    } t_dp_sts;

endpackage

@@ rtl/bfa_ram.sv @@
// Generic single-port-write, registered-read RAM.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/bfa_datapath.sv @@
// Datapath: configuration, request checks, map word scan and result register.
module bfa_datapath import bfa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [BASE_W-1:0]  i_cfg_data,
    input  t_req               i_req,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output t_result            o_result
);

    logic [BASE_W-1:0]  r_base;
    logic [COUNT_W-1:0] r_count;
    t_req               r_req;
    logic [WIDX_W-1:0]  r_ptr;
    logic [WIDX_W-1:0]  r_last;
    logic [WORD_SH-1:0] r_bit;
    logic               r_rd_valid;
    logic [NUM_WORDS-1:0] r_row_valid;
    t_result            r_result;

    logic [31:0]        lim32;
    logic [31:0]        s32;
    logic [31:0]        frame32;
    logic [31:0]        diff32;
    logic [31:0]        lm1;
    logic               misal;
    logic               out_range;
    logic [FIDX_W-1:0]  fidx;
    logic [WIDX_W-1:0]  rd_addr;
    logic               rd_en;
    logic [WORD_W-1:0]  rd_data;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  cand;
    logic [WORD_SH-1:0] pos;
    logic [FIDX_W-1:0]  gidx;
    logic [FIDX_W-1:0]  gpos;
    logic [31:0]        alloc_addr;
    logic [WORD_W-1:0]  wr_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                default:   r_base  <= r_base;
            endcase
        end
    end

    // Request checks on the captured beat.
    always_comb begin
        lim32 = (32'(r_count) < 32'(NUM_FRAMES)) ? 32'(r_count) : 32'(NUM_FRAMES);
        lm1     = lim32 - 32'd1;
        s32     = 32'(r_req.start_index);
        frame32 = r_req.free_address >> FRAME_SHIFT;
        diff32  = frame32 - 32'(r_base);
        misal   = |r_req.free_address[FRAME_SHIFT-1:0];
        out_range = (frame32 < 32'(r_base)) || (diff32 >= lim32);
        fidx    = (r_req.action == ACT_FREE) ? diff32[FIDX_W-1:0] : s32[FIDX_W-1:0];
    end

    always_comb begin
        o_sts.is_free = (r_req.action == ACT_FREE);
        if (r_req.action == ACT_FREE) begin
            o_sts.chk_ok   = !misal && !out_range;
            o_sts.chk_code = misal ? ST_MISALIGNED : ST_OUT_OF_RANGE;
        end else begin
            o_sts.chk_ok   = (s32 < lim32);
            o_sts.chk_code = ST_NO_FRAME;
        end
        o_sts.found     = |cand;
        o_sts.last_word = (r_ptr == r_last);
    end

    // Map read address and enable.
    assign rd_en   = i_cmd.first_rd || i_cmd.next_rd;
    assign rd_addr = i_cmd.first_rd ? fidx[FIDX_W-1:WORD_SH] : r_ptr + WIDX_W'(1);

    // A row that was never written since reset reads as all free.
    assign word = r_rd_valid ? rd_data : '0;

    // Free frames in the current word inside [start, limit).
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            gidx    = {r_ptr, WORD_SH'(b)};
            cand[b] = !word[b] && (32'(gidx) >= s32) && (32'(gidx) < lim32);
        end
    end

    // Lowest free frame in the word.
    always_comb begin
        pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                pos = WORD_SH'(b);
            end
        end
        gpos       = {r_ptr, pos};
        alloc_addr = (32'(r_base) + 32'(gpos)) << FRAME_SHIFT;
    end

    // Modified word: set the taken bit or clear the freed one.
    always_comb begin
        if (r_req.action == ACT_FREE) begin
            wr_data = word & ~(WORD_W'(1) << r_bit);
        end else begin
            wr_data = word | (WORD_W'(1) << pos);
        end
    end

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (r_ptr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Row valid bits stand in for clearing the map at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.wr) begin
            r_row_valid[r_ptr] <= 1'b1;
        end
    end

    // Request capture, scan pointer and read qualifier.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.first_rd) begin
            r_ptr  <= fidx[FIDX_W-1:WORD_SH];
            r_bit  <= fidx[WORD_SH-1:0];
            r_last <= lm1[FIDX_W-1:WORD_SH];
        end else if (i_cmd.next_rd) begin
            r_ptr <= rd_addr;
        end
        if (rd_en) begin
            r_rd_valid <= r_row_valid[rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_result.status <= i_cmd.code;
            if (i_cmd.code == ST_OK && r_req.action == ACT_ALLOC) begin
                r_result.frame_address <= alloc_addr;
            end else begin
                r_result.frame_address <= '0;
            end
        end
    end

    assign o_result = r_result;

endmodule

@@ rtl/bfa_ctrl.sv @@
// Controller: sequences request checks, the word scan and the write-back.
module bfa_ctrl import bfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.code = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.chk_ok) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = i_sts.chk_code;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.first_rd = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.is_free || i_sts.found) begin
                    o_cmd.wr  = 1'b1;
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end else if (i_sts.last_word) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_NO_FRAME;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.next_rd = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.fin;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

@@ rtl/bitmap_frame_allocator.sv @@
// Top level of the first-fit bitmap frame allocator.
//
// A request beat is taken when start is high and busy is low. i_req.action
// selects allocate (scan from start_index for the first free frame below
// the frame count) or free (release the frame at free_address).
// The result beat appears on o_result for one cycle, marked by o_done; the
// receiver cannot hold it off. busy drops in the cycle o_done is high, so a
// new request may be taken in that same cycle.
// A failed check returns its result without reading the map, a free reads
// one map word and writes it back, and an allocation reads the 32-bit map
// words in turn (one word per cycle through the map RAM's single read port)
// until one holds a free frame or the last word in range has been read.
// One request is handled at a time.
// Configuration: i_cfg_we writes base frame number (index 0) or frame count
// (index 1) at once; write only while busy is low and no result is pending.
// Reset (synchronous, active low) clears both registers and the row valid
// bits of the map, so every frame reads as free immediately after reset;
// there is no clearing pass.
module bitmap_frame_allocator import bfa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [BASE_W-1:0]  i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_done,
    output t_result            o_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bfa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_result)
    );

    // A result beat only follows a cycle of work on a request.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // An accepted request makes the block busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Failed requests return a zero address.
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> (o_result.frame_address == '0))
        else $error("nonzero address with a failure status");

    // Returned addresses are frame aligned.
    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.frame_address[FRAME_SHIFT-1:0] == '0))
        else $error("misaligned frame address returned");

endmodule

@@ tb/bitmap_frame_allocator_test.sv @@
// Self-checking testbench for the bitmap frame allocator: directed table, then random traffic.
module bitmap_frame_allocator_test import bfa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 58;
    localparam int TAIL_CYCLES = 40;
    localparam int NUM_ROWS    = 28;

    // A directed row either programs both registers or sends one request beat.
    // Requests marked ROW_KNOWN carry their result; ROW_PREDICTED ones are worked out.
    typedef enum logic [1:0] {
        ROW_SETTING,
        ROW_PREDICTED,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        t_req               req;
        logic [BASE_W-1:0]  base;
        logic [COUNT_W-1:0] count;
        t_result            known;
    } t_row;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_index = CFG_BASE;
    logic [BASE_W-1:0]  i_cfg_data  = '0;
    logic               start       = 1'b0;
    logic               busy;
    t_req               i_req       = '0;
    logic               o_done;
    t_result            o_result;

    // Shadow copy of the allocator state used to work out each result.
    bit                 shadow_used [NUM_FRAMES];
    logic [BASE_W-1:0]  shadow_base  = '0;
    logic [COUNT_W-1:0] shadow_count = '0;

    t_result            pending_results [$];
    int                 error_count  = 0;
    int                 quiet_cycles = 0;
    bit                 back_to_back = 1'b0;

    t_row directed_rows [NUM_ROWS] = '{
        // Straight out of reset the frame count is zero, so nothing is in range.
        '{ROW_KNOWN,     '{ACT_ALLOC, 11'd0,    32'h0000_0000}, '0, '0, '{ST_NO_FRAME,     32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'h0000_0000}, '0, '0, '{ST_OUT_OF_RANGE, 32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'h0000_0001}, '0, '0, '{ST_MISALIGNED,   32'h0}},
        // Full map at base zero.
        '{ROW_SETTING,   '0, 20'h00000, 11'd1024, '0},
        '{ROW_KNOWN,     '{ACT_ALLOC, 11'd0,    32'h0000_0000}, '0, '0, '{ST_OK, 32'h0000_0000}},
        '{ROW_KNOWN,     '{ACT_ALLOC, 11'd0,    32'h0000_0000}, '0, '0, '{ST_OK, 32'h0000_1000}},
        '{ROW_KNOWN,     '{ACT_ALLOC, 11'd1023, 32'h0000_0000}, '0, '0, '{ST_OK, 32'h003F_F000}},
        '{ROW_KNOWN,     '{ACT_ALLOC, 11'd1023, 32'h0000_0000}, '0, '0, '{ST_NO_FRAME, 32'h0}},
        '{ROW_KNOWN,     '{ACT_ALLOC, 11'd1024, 32'h0000_0000}, '0, '0, '{ST_NO_FRAME, 32'h0}},
        '{ROW_KNOWN,     '{ACT_ALLOC, 11'd2047, 32'hFFFF_FFFF}, '0, '0, '{ST_NO_FRAME, 32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd2047, 32'h003F_F000}, '0, '0, '{ST_OK, 32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'h0040_0000}, '0, '0, '{ST_OUT_OF_RANGE, 32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'hFFFF_F000}, '0, '0, '{ST_OUT_OF_RANGE, 32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'hFFFF_FFFF}, '0, '0, '{ST_MISALIGNED, 32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'h0000_0800}, '0, '0, '{ST_MISALIGNED, 32'h0}},
        // Freeing the same frame twice succeeds both times.
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'h0000_1000}, '0, '0, '{ST_OK, 32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'h0000_1000}, '0, '0, '{ST_OK, 32'h0}},
        '{ROW_KNOWN,     '{ACT_ALLOC, 11'd0,    32'h0000_0000}, '0, '0, '{ST_OK, 32'h0000_1000}},
        // Top base with a count above the map depth: addresses wrap.
        '{ROW_SETTING,   '0, 20'hFFFFF, 11'd2047, '0},
        '{ROW_PREDICTED, '{ACT_ALLOC, 11'd0,    32'h0000_0000}, '0, '0, '0},
        '{ROW_PREDICTED, '{ACT_ALLOC, 11'd1023, 32'h0000_0000}, '0, '0, '0},
        '{ROW_PREDICTED, '{ACT_FREE,  11'd0,    32'hFFFF_F000}, '0, '0, '0},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'hFFFF_E000}, '0, '0, '{ST_OUT_OF_RANGE, 32'h0}},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'h0000_1000}, '0, '0, '{ST_OUT_OF_RANGE, 32'h0}},
        // Small window with a nonzero base.
        '{ROW_SETTING,   '0, 20'h00005, 11'd8, '0},
        '{ROW_PREDICTED, '{ACT_ALLOC, 11'd0,    32'h0000_0000}, '0, '0, '0},
        '{ROW_PREDICTED, '{ACT_FREE,  11'd0,    32'h0000_C000}, '0, '0, '0},
        '{ROW_KNOWN,     '{ACT_FREE,  11'd0,    32'h0000_D000}, '0, '0, '{ST_OUT_OF_RANGE, 32'h0}}
    };

    bitmap_frame_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one request to the shadow map and return the result it must produce.
    function automatic t_result predict_result(input t_req item);
        t_result         res;
        int              limit;
        longint unsigned frame_no;
        res.status        = ST_NO_FRAME;
        res.frame_address = '0;
        limit = (shadow_count < NUM_FRAMES) ? int'(shadow_count) : NUM_FRAMES;
        if (item.action == ACT_ALLOC) begin
            for (int i = int'(item.start_index); i < limit; i++) begin
                if (!shadow_used[i]) begin
                    shadow_used[i]    = 1'b1;
                    frame_no          = longint'(shadow_base) + longint'(i);
                    res.frame_address = ADDR_W'(frame_no << FRAME_SHIFT);
                    res.status        = ST_OK;
                    break;
                end
            end
        end else if (item.free_address[FRAME_SHIFT-1:0] != '0) begin
            res.status = ST_MISALIGNED;
        end else begin
            frame_no = longint'(item.free_address >> FRAME_SHIFT);
            if (frame_no < shadow_base || frame_no - shadow_base >= longint'(limit)) begin
                res.status = ST_OUT_OF_RANGE;
            end else begin
                shadow_used[frame_no - shadow_base] = 1'b0;
                res.status = ST_OK;
            end
        end
        return res;
    endfunction

    // Stop sending and hold until every outstanding result beat has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Program base and count on an idle block; upper data bits on the count write are noise.
    task automatic apply_setting(input logic [BASE_W-1:0] base, input logic [COUNT_W-1:0] count);
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        shadow_base = base;
        i_cfg_index <= CFG_COUNT;
        i_cfg_data  <= {(BASE_W-COUNT_W)'($urandom), count};
        @(posedge i_clk);
        shadow_count = count;
        i_cfg_we <= 1'b0;
    endtask

    // Send one request beat after a random gap (none back to back) and queue the result it should give.
    task automatic send_request(input t_req item, input bit use_known, input t_result known);
        int      gap;
        t_result predicted;
        gap = back_to_back ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= item;
        do @(posedge i_clk); while (busy);
        predicted = predict_result(item);
        pending_results.push_back(use_known ? known : predicted);
    endtask

    // Compare every result beat with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d, frame_address %h",
                       o_result.status, o_result.frame_address);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    error_count++;
                end
                if (o_result.frame_address !== want.frame_address) begin
                    $error("frame_address: expected %h, got %h",
                           want.frame_address, o_result.frame_address);
                    error_count++;
                end
            end
        end
    end

    // End the run when no beat of any kind has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $error("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_req               item;
        logic [BASE_W-1:0]  set_base;
        logic [COUNT_W-1:0] set_count;
        int                 limit;
        int                 roll;
        int                 slot;
        logic [ADDR_W-1:0]  aligned;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_SETTING) begin
                apply_setting(directed_rows[k].base, directed_rows[k].count);
            end else begin
                send_request(directed_rows[k].req, directed_rows[k].kind == ROW_KNOWN,
                             directed_rows[k].known);
            end
        end

        // Random phases, each under its own base and count.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    set_base  = '0;
                    set_count = 11'd1024;
                end
                1: begin
                    set_base  = '1;
                    set_count = '1;
                end
                2: begin
                    set_base  = BASE_W'($urandom);
                    set_count = '0;
                end
                3: begin
                    set_base  = BASE_W'($urandom);
                    set_count = 11'd1;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: set_base = '0;
                        1: set_base = {BASE_W{1'b1}} - BASE_W'($urandom_range(0, 1100));
                        default: set_base = BASE_W'($urandom);
                    endcase
                    case ($urandom_range(0, 3))
                        0: set_count = COUNT_W'($urandom_range(1, 40));
                        1: set_count = COUNT_W'($urandom_range(0, 2047));
                        default: set_count = COUNT_W'($urandom_range(60, 300));
                    endcase
                end
            endcase
            apply_setting(set_base, set_count);
            back_to_back = (phase % 3 == 1);
            limit = (set_count < NUM_FRAMES) ? int'(set_count) : NUM_FRAMES;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                item.action       = ($urandom_range(0, 1) == 0) ? ACT_ALLOC : ACT_FREE;
                item.start_index  = START_W'($urandom);
                item.free_address = $urandom;
                roll = $urandom_range(0, 99);
                if (item.action == ACT_ALLOC) begin
                    // Mostly scans from the bottom or from a start index in [0, limit].
                    if (roll < 55) begin
                        item.start_index = '0;
                    end else if (roll < 85) begin
                        item.start_index = START_W'($urandom_range(0, limit));
                    end
                end else begin
                    // Mostly frees of frames inside the window, some misaligned, some raw.
                    slot    = (limit > 0) ? $urandom_range(0, limit - 1) : 0;
                    aligned = ADDR_W'((longint'(set_base) + longint'(slot)) << FRAME_SHIFT);
                    if (roll < 75) begin
                        item.free_address = aligned;
                    end else if (roll < 88) begin
                        item.free_address = aligned
                            | ADDR_W'($urandom_range(1, (1 << FRAME_SHIFT) - 1));
                    end
                end
                send_request(item, 1'b0, '0);
            end
            back_to_back = 1'b0;
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
